[rtl/core/dmx_delta_to_midi_encoder_assert.svh]
// assertion macros used by the checker file of the delta encoder
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef DMX_DELTA_TO_MIDI_ENCODER_ASSERT_SVH
`define DMX_DELTA_TO_MIDI_ENCODER_ASSERT_SVH

// same-cycle implication
`define DMXE_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define DMXE_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");

`endif

[rtl/core/dmxe_pkg.sv]
// types, codes and constants of the dmx delta to midi encoder
// no dependencies; used by every module of the block but dmxe_ram
package dmxe_pkg;

   localparam int CFG_W     = 13;
   localparam int POS_W     = 16;
   localparam int CNT_W     = 13;
   localparam int BANK_W    = 3;
   localparam int BANK_LSB  = 11;
   localparam int CSR_IDX_W = 1;
   localparam int STEP_W    = 3;

   localparam logic [POS_W-1:0] POS_CAP = 16'hFFFF;

   localparam logic [CFG_W-1:0] BUDGET_RESET = 13'd64;
   localparam logic [CFG_W-1:0] WINDOW_RESET = 13'd16;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_BUDGET = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_WINDOW  = 1'b1;

   localparam logic [1:0] CMD_LEVEL = 2'd0;
   localparam logic [1:0] CMD_EOF   = 2'd1;
   localparam logic [1:0] CMD_RESET = 2'd2;

   localparam logic [7:0] ST_NOTE_ON  = 8'h90;
   localparam logic [7:0] ST_NOTE_OFF = 8'h80;
   localparam logic [7:0] ST_CC       = 8'hBF;
   localparam logic [6:0] CC_NUMBER   = 7'd127;

   localparam logic [6:0] CODE_BANK_ZERO = 7'd0;
   localparam logic [6:0] CODE_KNOCK_A   = 7'd101;
   localparam logic [6:0] CODE_KNOCK_B   = 7'd120;
   localparam logic [6:0] CODE_KNOCK_C   = 7'd107;
   localparam logic [6:0] CODE_WATCHDOG  = 7'd127;

   localparam logic [STEP_W-1:0] STEP_BANK  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_NOTE  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_KNOCK_LAST = 3'd4;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] channel_value;
   } req_type;

   typedef struct packed {
      logic [7:0] status_byte;
      logic [6:0] data_one;
      logic [6:0] data_two;
      logic       last_of_run;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_CHAN,
      KIND_WDOG,
      KIND_KNOCK
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic              bank_msg;
      logic [BANK_W-1:0] bank;
      logic [7:0]        status;
      logic [6:0]        note;
      logic [6:0]        velocity;
   } burst_type;

   // control code of each message of the reset sequence
   function automatic logic [6:0] knock_code(input logic [STEP_W-1:0] step);
      logic [6:0] code;
      case (step)
         3'd0:    code = CODE_BANK_ZERO;
         3'd1:    code = CODE_KNOCK_A;
         3'd2:    code = CODE_KNOCK_B;
         3'd3:    code = CODE_KNOCK_C;
         default: code = CODE_WATCHDOG;
      endcase
      return code;
   endfunction

endpackage

[rtl/core/dmxe_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module dmxe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/dmxe_engine.sv]
// read-modify-write engine: frame counters, level store access, send decision
// depends on dmxe_pkg; drives the level store ram and hands bursts to dmxe_emit
module dmxe_engine #(
   parameter int NUM_CHANNELS = 4096,
   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  dmxe_pkg::req_type          req_data,
   input  logic [dmxe_pkg::CFG_W-1:0] frame_budget,
   input  logic [dmxe_pkg::CFG_W-1:0] idle_window,
   output logic                       ram_wr_en,
   output logic [IDX_W-1:0]           ram_wr_addr,
   output logic [7:0]                 ram_wr_data,
   output logic [IDX_W-1:0]           ram_rd_addr,
   input  logic [7:0]                 ram_rd_data,
   input  logic                       burst_ready,
   output logic                       burst_valid,
   output dmxe_pkg::burst_type        burst
);
   import dmxe_pkg::*;

   localparam logic [POS_W-1:0] NUM_POS  = POS_W'(NUM_CHANNELS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

   logic [POS_W-1:0]  fpos_ff, fpos_in;
   logic              p1_valid_ff, p1_valid_in;
   logic [1:0]        p1_cmd_ff, p1_cmd_in;
   logic [7:0]        p1_level_ff, p1_level_in;
   logic [POS_W-1:0]  p1_pos_ff, p1_pos_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              hit_ff, hit_in;
   logic [POS_W-1:0]  wstart_ff, wstart_in;
   logic [POS_W-1:0]  resume_ff, resume_in;
   logic [BANK_W-1:0] bank_ff, bank_in;
   logic              clear_ff, clear_in;
   logic [IDX_W-1:0]  clr_addr_ff, clr_addr_in;
   logic              fwd_valid_ff, fwd_valid_in;
   logic [IDX_W-1:0]  fwd_addr_ff;
   logic [7:0]        fwd_data_ff;

   logic              accept;
   logic              fire;
   logic [7:0]        old_level;
   logic              eligible;
   logic              changed;
   logic [POS_W:0]    wend;
   logic              in_win;
   logic              want;
   logic              over;
   logic              send;
   logic [BANK_W-1:0] bank_new;
   logic              bank_diff;
   logic [1:0]        inc;
   logic [CNT_W:0]    count_sum;
   logic              write_level;

   assign fire      = p1_valid_ff && burst_ready;
   assign req_stall = clear_ff || (p1_valid_ff && (!fire || p1_cmd_ff == CMD_RESET));
   assign accept    = req_valid && !req_stall;

   // store read: new item when one enters, else the held item again
   assign ram_rd_addr = accept ? fpos_ff[IDX_W-1:0] : p1_pos_ff[IDX_W-1:0];

   // a write in the cycle before is not yet in the read data, so it is forwarded
   assign old_level = (fwd_valid_ff && fwd_addr_ff == p1_pos_ff[IDX_W-1:0]) ?
                      fwd_data_ff : ram_rd_data;

   assign eligible  = (p1_pos_ff < NUM_POS) && !hit_ff && (p1_pos_ff >= resume_ff);
   assign changed   = p1_level_ff != old_level;
   assign wend      = {1'b0, wstart_ff} + (POS_W+1)'(idle_window);
   assign in_win    = (p1_pos_ff >= wstart_ff) && ({1'b0, p1_pos_ff} < wend);
   assign want      = eligible && (changed || in_win);
   assign over      = count_ff >= frame_budget;
   assign send      = want && !over;
   assign bank_new  = p1_pos_ff[BANK_LSB+BANK_W-1:BANK_LSB];
   assign bank_diff = bank_new != bank_ff;
   assign inc       = send ? (bank_diff ? 2'd2 : 2'd1) : 2'd0;
   assign count_sum = {1'b0, count_ff} + (CNT_W+1)'(inc);

   assign write_level = fire && p1_cmd_ff == CMD_LEVEL && send;

   assign ram_wr_en   = clear_ff || write_level;
   assign ram_wr_addr = clear_ff ? clr_addr_ff : p1_pos_ff[IDX_W-1:0];
   assign ram_wr_data = clear_ff ? 8'd0 : p1_level_ff;

   always_comb begin
      fpos_in      = fpos_ff;
      p1_valid_in  = p1_valid_ff;
      p1_cmd_in    = p1_cmd_ff;
      p1_level_in  = p1_level_ff;
      p1_pos_in    = p1_pos_ff;
      count_in     = count_ff;
      hit_in       = hit_ff;
      wstart_in    = wstart_ff;
      resume_in    = resume_ff;
      bank_in      = bank_ff;
      clear_in     = clear_ff;
      clr_addr_in  = clr_addr_ff;
      fwd_valid_in = write_level;
      burst_valid  = 1'b0;

      burst.kind     = KIND_CHAN;
      burst.bank_msg = bank_diff;
      burst.bank     = bank_new;
      burst.status   = (p1_pos_ff[BANK_LSB-1] ? ST_NOTE_OFF : ST_NOTE_ON) |
                       {4'd0, p1_pos_ff[BANK_LSB-2:BANK_LSB-5]};
      burst.note     = {p1_pos_ff[5:0], p1_level_ff[7]};
      burst.velocity = p1_level_ff[6:0];

      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_IDX) begin
            clear_in = 1'b0;
         end
      end

      if (fire) begin
         p1_valid_in = 1'b0;
         case (p1_cmd_ff)
            CMD_LEVEL: begin
               burst_valid = send;
               if (want && over) begin
                  resume_in = p1_pos_ff;
                  hit_in    = 1'b1;
               end
               if (send) begin
                  bank_in  = bank_new;
                  count_in = count_sum[CNT_W] ? {CNT_W{1'b1}} : count_sum[CNT_W-1:0];
               end
            end
            CMD_EOF: begin
               burst_valid = 1'b1;
               burst.kind  = KIND_WDOG;
               if (!over) begin
                  resume_in = '0;
               end
               wstart_in = (wend > {1'b0, p1_pos_ff}) ? '0 : wend[POS_W-1:0];
               count_in  = '0;
               hit_in    = 1'b0;
            end
            CMD_RESET: begin
               burst_valid = 1'b1;
               burst.kind  = KIND_KNOCK;
               count_in    = '0;
               hit_in      = 1'b0;
               wstart_in   = '0;
               resume_in   = '0;
               bank_in     = '0;
               clear_in    = 1'b1;
               clr_addr_in = '0;
            end
            default: begin
               burst_valid = 1'b0;
            end
         endcase
      end

      if (accept) begin
         p1_valid_in = 1'b1;
         p1_cmd_in   = req_data.cmd;
         p1_level_in = req_data.channel_value;
         p1_pos_in   = fpos_ff;
         case (req_data.cmd)
            CMD_LEVEL: begin
               if (fpos_ff != POS_CAP) begin
                  fpos_in = fpos_ff + 1'b1;
               end
            end
            CMD_EOF, CMD_RESET: begin
               fpos_in = '0;
            end
            default: begin
               fpos_in = fpos_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fpos_ff      <= '0;
         p1_valid_ff  <= 1'b0;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         wstart_ff    <= '0;
         resume_ff    <= '0;
         bank_ff      <= '0;
         clear_ff     <= 1'b1;
         clr_addr_ff  <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         fpos_ff      <= fpos_in;
         p1_valid_ff  <= p1_valid_in;
         count_ff     <= count_in;
         hit_ff       <= hit_in;
         wstart_ff    <= wstart_in;
         resume_ff    <= resume_in;
         bank_ff      <= bank_in;
         clear_ff     <= clear_in;
         clr_addr_ff  <= clr_addr_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_cmd_ff   <= p1_cmd_in;
      p1_level_ff <= p1_level_in;
      p1_pos_ff   <= p1_pos_in;
      fwd_addr_ff <= p1_pos_ff[IDX_W-1:0];
      fwd_data_ff <= p1_level_ff;
   end

endmodule

[rtl/core/dmxe_emit.sv]
// message sequencer: expands one burst into midi messages, one message per cycle while rsp is not stalled
// depends on dmxe_pkg; fed by dmxe_engine, drives the result channel register
module dmxe_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                burst_valid,
   input  dmxe_pkg::burst_type burst,
   output logic                burst_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output dmxe_pkg::rsp_type   rsp_data
);
   import dmxe_pkg::*;

   logic              held_valid_ff, held_valid_in;
   burst_type         held_ff, held_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic              out_free;
   logic              emit;
   rsp_type           msg;

   assign out_free    = !out_valid_ff || !rsp_stall;
   assign emit        = held_valid_ff && out_free;
   assign burst_ready = !held_valid_ff || (emit && msg.last_of_run);

   always_comb begin
      msg.status_byte = ST_CC;
      msg.data_one    = CC_NUMBER;
      msg.data_two    = CODE_WATCHDOG;
      msg.last_of_run = 1'b1;
      case (held_ff.kind)
         KIND_CHAN: begin
            if (step_ff == STEP_BANK) begin
               msg.data_two    = {4'd0, held_ff.bank};
               msg.last_of_run = 1'b0;
            end else begin
               msg.status_byte = held_ff.status;
               msg.data_one    = held_ff.note;
               msg.data_two    = held_ff.velocity;
            end
         end
         KIND_KNOCK: begin
            msg.data_two    = knock_code(step_ff);
            msg.last_of_run = step_ff == STEP_KNOCK_LAST;
         end
         default: begin
            msg.data_two = CODE_WATCHDOG;
         end
      endcase
   end

   always_comb begin
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      step_in       = step_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;

      if (out_free) begin
         out_valid_in = emit;
         out_in       = msg;
      end

      if (burst_valid && burst_ready) begin
         held_valid_in = 1'b1;
         held_in       = burst;
         step_in       = (burst.kind == KIND_CHAN && !burst.bank_msg) ? STEP_NOTE : STEP_BANK;
      end else if (emit) begin
         if (msg.last_of_run) begin
            held_valid_in = 1'b0;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      step_ff <= step_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

[rtl/core/dmx_delta_to_midi_encoder.sv]
// top level of the dmx delta to midi encoder: config registers and the three units
// depends on dmxe_pkg, dmxe_ram, dmxe_engine and dmxe_emit
//
// req channel: one item per dmx channel level (cmd level), end of frame or protocol
// reset. rsp channel: midi short messages, last_of_run marks the final one of an item.
// csr port: index 0 frame_budget, index 1 idle_window, to be written by the user only
// while idle; the block does not enforce it. an accepted item passes the engine stage,
// the sequencer's held burst and the output register before its first message is on
// rsp. a level item that sends puts out a bank change if its bank differs, then its
// note; the sequencer puts out one message per cycle while rsp is not stalled, and the
// engine holds the next item meanwhile. the level store is read for each item and
// written only when it sends. a protocol reset sends 5 messages and clears the level
// store with one entry per cycle, so no item is taken until the clear is through.
// reset: the clear runs over every entry with req_stall high; config registers return
// to 64 and 16. a stalled rsp holds its message; the sequencer and the engine then
// back up; req_stall rises once the item in the engine cannot hand over its messages.
module dmx_delta_to_midi_encoder #(
   parameter int NUM_CHANNELS = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  dmxe_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output dmxe_pkg::rsp_type              rsp_data,
   input  logic                           csr_wr_en,
   input  logic [dmxe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dmxe_pkg::CFG_W-1:0]     csr_wdata
);
   import dmxe_pkg::*;

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   logic [CFG_W-1:0] budget_ff, budget_in;
   logic [CFG_W-1:0] window_ff, window_in;

   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [7:0]       ram_wr_data;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [7:0]       ram_rd_data;
   logic             burst_valid;
   logic             burst_ready;
   burst_type        burst;

   always_comb begin
      budget_in = budget_ff;
      window_in = window_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_BUDGET: budget_in = csr_wdata;
            CSR_IDLE_WINDOW:  window_in = csr_wdata;
            default: begin
               budget_in = budget_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BUDGET_RESET;
         window_ff <= WINDOW_RESET;
      end else begin
         budget_ff <= budget_in;
         window_ff <= window_in;
      end
   end

   dmxe_ram #(
      .WIDTH (8),
      .DEPTH (NUM_CHANNELS)
   ) u_levels (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   dmxe_engine #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .frame_budget (budget_ff),
      .idle_window  (window_ff),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .burst_ready  (burst_ready),
      .burst_valid  (burst_valid),
      .burst        (burst)
   );

   dmxe_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .burst_valid (burst_valid),
      .burst       (burst),
      .burst_ready (burst_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

[rtl/core/dmxe_checker.sv]
// port-level checks of the dmx delta to midi encoder, bound to the top level
// depends on dmxe_pkg and dmx_delta_to_midi_encoder_assert.svh
`include "dmx_delta_to_midi_encoder_assert.svh"

module dmxe_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input dmxe_pkg::rsp_type rsp_data
);
   import dmxe_pkg::*;

   `DMXE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `DMXE_ASSERT_IMPLY(a_status_range, clock, reset, rsp_valid, rsp_data.status_byte[7:6] == 2'b10)
   `DMXE_ASSERT_IMPLY(a_cc_number, clock, reset, rsp_valid && rsp_data.status_byte == ST_CC, rsp_data.data_one == CC_NUMBER)
   `DMXE_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && req_stall)

endmodule

bind dmx_delta_to_midi_encoder dmxe_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[tb/tb_dmx_delta_to_midi_encoder.sv]
// testbench of dmx_delta_to_midi_encoder: a directed table, then random dmx frames,
// each midi message checked in order against the table or an encoder model kept in this file
// depends on dmxe_pkg and the rtl of the block
module tb_dmx_delta_to_midi_encoder;
   timeunit 1ns;
   timeprecision 1ps;
   import dmxe_pkg::*;

   localparam int NUM_CH = 4096;
   localparam int unsigned CYCLE_LIMIT = 5000000;
   localparam int unsigned RANDOM_ITEMS = 206;
   localparam int unsigned QUIET_CYCLES = 16;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int unsigned POS_LIMIT = 65535;
   localparam int unsigned COUNT_LIMIT = 8191;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      req_type              req;
      logic [CSR_IDX_W-1:0] csr_idx;
      logic [CFG_W-1:0]     csr_val;
      int                   n_typed;
      rsp_type [4:0]        typed;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   // encoder model state
   logic [CFG_W-1:0] budget_cfg = BUDGET_RESET;
   logic [CFG_W-1:0] window_cfg = WINDOW_RESET;
   logic [7:0]       level_store [NUM_CH];
   int unsigned      chan_pos = 0;
   int unsigned      msg_count = 0;
   int unsigned      win_start = 0;
   int unsigned      resume_chan = 0;
   logic [2:0]       cur_bank = '0;
   bit               frame_dropped = 1'b0;

   rsp_type      fresh_midi[$];
   rsp_type      pending_midi[$];
   stim_row_type directed_rows[$];
   int unsigned  mismatch_count = 0;
   int unsigned  random_items = 0;
   bit           clear_pending = 1'b1;
   bit           sender_calm = 1'b0;
   int unsigned  sender_mode_left = 0;
   bit           rsp_calm = 1'b0;
   int unsigned  rsp_mode_left = 0;
   int unsigned  rsp_stall_left = 0;

   dmx_delta_to_midi_encoder #(.NUM_CHANNELS(NUM_CH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic rsp_type midi(logic [7:0] st, logic [6:0] d1, logic [6:0] d2, logic last);
      rsp_type m;
      m.status_byte = st;
      m.data_one = d1;
      m.data_two = d2;
      m.last_of_run = last;
      return m;
   endfunction

   function automatic stim_row_type item_row(logic [1:0] cmd, logic [7:0] lvl, int n_typed,
                                             rsp_type m);
      stim_row_type row;
      row.kind = ROW_ITEM;
      row.req.cmd = cmd;
      row.req.channel_value = lvl;
      row.csr_idx = '0;
      row.csr_val = '0;
      row.n_typed = n_typed;
      row.typed = '0;
      row.typed[0] = m;
      return row;
   endfunction

   function automatic stim_row_type reset_row();
      stim_row_type row;
      row = item_row(CMD_RESET, 8'h00, 5, midi(ST_CC, CC_NUMBER, CODE_BANK_ZERO, 1'b0));
      row.typed[1] = midi(ST_CC, CC_NUMBER, CODE_KNOCK_A, 1'b0);
      row.typed[2] = midi(ST_CC, CC_NUMBER, CODE_KNOCK_B, 1'b0);
      row.typed[3] = midi(ST_CC, CC_NUMBER, CODE_KNOCK_C, 1'b0);
      row.typed[4] = midi(ST_CC, CC_NUMBER, CODE_WATCHDOG, 1'b1);
      return row;
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      stim_row_type row;
      row = item_row(CMD_UNUSED, 8'h00, 0, '0);
      row.kind = ROW_CSR;
      row.csr_idx = idx;
      row.csr_val = val;
      return row;
   endfunction

   function automatic void add_row(stim_row_type row);
      directed_rows = {directed_rows, row};
   endfunction

   function automatic void add_msg(rsp_type m);
      fresh_midi = {fresh_midi, m};
   endfunction

   // messages caused by one item, model state updated
   function void encode_item(input req_type r);
      int unsigned ch, bank, offs, t;
      logic [7:0]  lvl;
      bit          changed, in_win;
      fresh_midi.delete();
      lvl = r.channel_value;
      case (r.cmd)
         CMD_LEVEL: begin
            ch = chan_pos;
            if (chan_pos < POS_LIMIT) chan_pos++;
            if (ch < NUM_CH && !frame_dropped && ch >= resume_chan) begin
               changed = lvl != level_store[ch];
               in_win = ch >= win_start && ch < win_start + window_cfg;
               if (changed || in_win) begin
                  if (msg_count >= budget_cfg) begin
                     resume_chan = ch;
                     frame_dropped = 1'b1;
                  end else begin
                     bank = ch / 2048;
                     level_store[ch] = lvl;
                     if (cur_bank != bank) begin
                        cur_bank = 3'(bank);
                        add_msg(midi(ST_CC, CC_NUMBER, 7'(bank), 1'b0));
                        if (msg_count < COUNT_LIMIT) msg_count++;
                     end
                     offs = ch - bank * 2048;
                     t = offs % 1024;
                     add_msg(midi((offs < 1024 ? ST_NOTE_ON : ST_NOTE_OFF)
                                     | 8'((t >> 6) & 15),
                                  7'(((t << 1) & 127) | lvl[7]), lvl[6:0], 1'b0));
                     if (msg_count < COUNT_LIMIT) msg_count++;
                  end
               end
            end
         end
         CMD_EOF: begin
            if (msg_count < budget_cfg) resume_chan = 0;
            win_start = win_start + window_cfg;
            if (win_start > chan_pos) win_start = 0;
            add_msg(midi(ST_CC, CC_NUMBER, CODE_WATCHDOG, 1'b0));
            chan_pos = 0;
            msg_count = 0;
            frame_dropped = 1'b0;
         end
         CMD_RESET: begin
            foreach (level_store[k]) level_store[k] = 8'h00;
            chan_pos = 0;
            msg_count = 0;
            frame_dropped = 1'b0;
            win_start = 0;
            resume_chan = 0;
            cur_bank = '0;
            add_msg(midi(ST_CC, CC_NUMBER, CODE_BANK_ZERO, 1'b0));
            add_msg(midi(ST_CC, CC_NUMBER, CODE_KNOCK_A, 1'b0));
            add_msg(midi(ST_CC, CC_NUMBER, CODE_KNOCK_B, 1'b0));
            add_msg(midi(ST_CC, CC_NUMBER, CODE_KNOCK_C, 1'b0));
            add_msg(midi(ST_CC, CC_NUMBER, CODE_WATCHDOG, 1'b0));
         end
         default: ;
      endcase
      if (fresh_midi.size() > 0) fresh_midi[fresh_midi.size() - 1].last_of_run = 1'b1;
   endfunction

   function int unsigned pick_gap();
      int unsigned roll;
      if (sender_mode_left == 0) begin
         sender_calm = !sender_calm;
         sender_mode_left = $urandom_range(60, 10);
      end else begin
         sender_mode_left--;
      end
      if (sender_calm) return 0;
      roll = $urandom_range(99);
      if (roll < 50) return 0;
      if (roll < 94) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   task note_mismatch(input string what, input int unsigned got, input int unsigned want);
      $display("mismatch in %s: got %0h, expected %0h", what, got, want);
      mismatch_count++;
   endtask

   task automatic send_item(input req_type r, input int n_typed, input rsp_type [4:0] typed);
      int unsigned gap;
      int k;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      encode_item(r);
      if (n_typed < 0) begin
         for (k = 0; k < fresh_midi.size(); k++) pending_midi = {pending_midi, fresh_midi[k]};
      end else begin
         for (k = 0; k < n_typed; k++) pending_midi = {pending_midi, typed[k]};
      end
      if (r.cmd == CMD_RESET) clear_pending = 1'b1;
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (pending_midi.size() != 0) @(posedge clock);
      repeat (clear_pending ? NUM_CH + QUIET_CYCLES : QUIET_CYCLES) @(posedge clock);
      clear_pending = 1'b0;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      drain_all();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_FRAME_BUDGET) budget_cfg = val;
      else window_cfg = val;
   endtask

   task automatic play_frame(input int unsigned len, input int unsigned change_pct,
                             input bit noisy);
      req_type r;
      int unsigned k;
      for (k = 0; k < len && random_items < RANDOM_ITEMS; k++) begin
         r.channel_value = 8'($urandom_range(255));
         if (noisy && $urandom_range(99) < 2) begin
            r.cmd = CMD_RESET;
         end else if (noisy && $urandom_range(99) < 3) begin
            r.cmd = CMD_UNUSED;
         end else begin
            r.cmd = CMD_LEVEL;
            if (chan_pos < NUM_CH && $urandom_range(99) >= change_pct)
               r.channel_value = level_store[chan_pos];
            else if ($urandom_range(9) == 0)
               r.channel_value = $urandom_range(1) ? 8'hFF : 8'h00;
         end
         send_item(r, -1, '0);
         random_items++;
      end
      if (!noisy || $urandom_range(99) >= 5) begin
         r.cmd = CMD_EOF;
         r.channel_value = 8'($urandom_range(255));
         send_item(r, -1, '0);
         random_items++;
      end
   endtask

   always @(posedge clock) begin
      if (rsp_mode_left == 0) begin
         rsp_calm = !rsp_calm;
         rsp_mode_left = $urandom_range(300, 40);
      end else begin
         rsp_mode_left--;
      end
      if (rsp_stall_left > 0)
         rsp_stall_left--;
      else if (!rsp_calm && $urandom_range(99) < 30)
         rsp_stall_left = ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(3, 1);
      rsp_stall <= (rsp_stall_left > 0);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_midi.size() == 0) begin
            note_mismatch("message with nothing pending", 32'(rsp_data), 0);
         end else begin
            want = pending_midi.pop_front();
            if (rsp_data.status_byte !== want.status_byte)
               note_mismatch("status_byte", 32'(rsp_data.status_byte),
                             32'(want.status_byte));
            if (rsp_data.data_one !== want.data_one)
               note_mismatch("data_one", 32'(rsp_data.data_one), 32'(want.data_one));
            if (rsp_data.data_two !== want.data_two)
               note_mismatch("data_two", 32'(rsp_data.data_two), 32'(want.data_two));
            if (rsp_data.last_of_run !== want.last_of_run)
               note_mismatch("last_of_run", 32'(rsp_data.last_of_run),
                             32'(want.last_of_run));
         end
      end
   end

   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      rsp_type     wdog;
      int unsigned frames, f;
      int          k;
      foreach (level_store[k]) level_store[k] = 8'h00;
      wdog = midi(ST_CC, CC_NUMBER, CODE_WATCHDOG, 1'b1);

      // defaults after reset: budget 64, window 16
      add_row(item_row(CMD_LEVEL, 8'h00, 1, midi(ST_NOTE_ON, 7'd0, 7'd0, 1'b1)));
      add_row(item_row(CMD_LEVEL, 8'hFF, 1, midi(ST_NOTE_ON, 7'd3, 7'd127, 1'b1)));
      add_row(item_row(CMD_LEVEL, 8'h80, -1, '0));
      add_row(item_row(CMD_UNUSED, 8'hAA, 0, '0));
      add_row(item_row(CMD_LEVEL, 8'h7F, -1, '0));
      add_row(item_row(CMD_EOF, 8'h00, 1, wdog));
      add_row(reset_row());
      add_row(item_row(CMD_UNUSED, 8'h55, 0, '0));
      // zero budget drops the whole frame
      add_row(csr_row(CSR_FRAME_BUDGET, 13'd0));
      add_row(item_row(CMD_LEVEL, 8'd200, 0, '0));
      add_row(item_row(CMD_LEVEL, 8'd1, 0, '0));
      add_row(item_row(CMD_EOF, 8'hFF, 1, wdog));
      // no refresh window: unchanged level sends nothing
      add_row(csr_row(CSR_FRAME_BUDGET, 13'h1FFF));
      add_row(csr_row(CSR_IDLE_WINDOW, 13'd0));
      add_row(item_row(CMD_LEVEL, 8'h00, 0, '0));
      add_row(item_row(CMD_LEVEL, 8'd37, -1, '0));
      add_row(item_row(CMD_EOF, 8'h00, 1, wdog));
      // budget used up exactly, next frame resumes at the dropped channel
      add_row(csr_row(CSR_FRAME_BUDGET, 13'd2));
      add_row(csr_row(CSR_IDLE_WINDOW, 13'h1FFF));
      add_row(item_row(CMD_LEVEL, 8'd9, -1, '0));
      add_row(item_row(CMD_LEVEL, 8'h00, -1, '0));
      add_row(item_row(CMD_LEVEL, 8'hFF, -1, '0));
      add_row(item_row(CMD_LEVEL, 8'd77, -1, '0));
      add_row(item_row(CMD_EOF, 8'h00, 1, wdog));
      add_row(item_row(CMD_LEVEL, 8'd5, 0, '0));
      add_row(item_row(CMD_LEVEL, 8'd6, 0, '0));
      add_row(item_row(CMD_LEVEL, 8'd3, -1, '0));
      add_row(item_row(CMD_EOF, 8'h00, 1, wdog));
      add_row(reset_row());

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < directed_rows.size(); k++) begin
         if (directed_rows[k].kind == ROW_CSR)
            write_csr(directed_rows[k].csr_idx, directed_rows[k].csr_val);
         else
            send_item(directed_rows[k].req, directed_rows[k].n_typed, directed_rows[k].typed);
      end

      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(6))
            0:       write_csr(CSR_FRAME_BUDGET, 13'd0);
            1:       write_csr(CSR_FRAME_BUDGET, 13'h1FFF);
            2, 3:    write_csr(CSR_FRAME_BUDGET, 13'($urandom_range(3, 1)));
            4:       write_csr(CSR_FRAME_BUDGET, 13'($urandom_range(30, 4)));
            default: write_csr(CSR_FRAME_BUDGET, 13'($urandom_range(4096, 31)));
         endcase
         case ($urandom_range(5))
            0:       write_csr(CSR_IDLE_WINDOW, 13'd0);
            1:       write_csr(CSR_IDLE_WINDOW, 13'h1FFF);
            2:       write_csr(CSR_IDLE_WINDOW, 13'($urandom_range(2, 1)));
            default: write_csr(CSR_IDLE_WINDOW, 13'($urandom_range(24, 3)));
         endcase
         frames = $urandom_range(6, 2);
         for (f = 0; f < frames && random_items < RANDOM_ITEMS; f++) begin
            case ($urandom_range(9))
               0:       play_frame(0, 10, 1'b1);
               1:       play_frame($urandom_range(90, 41), $urandom_range(30, 2), 1'b1);
               default: play_frame($urandom_range(40, 1),
                                   ($urandom_range(3) == 0) ? 80 : $urandom_range(30, 2), 1'b1);
            endcase
         end
      end

      drain_all();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/dmxe_pkg.sv
rtl/core/dmxe_ram.sv
rtl/core/dmxe_engine.sv
rtl/core/dmxe_emit.sv
rtl/core/dmx_delta_to_midi_encoder.sv
rtl/core/dmxe_checker.sv
tb/tb_dmx_delta_to_midi_encoder.sv
